[design/cau_pkg.sv]
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int WORD_BITS = 32;
   localparam int QUO_BITS = 32;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] a_real;
      logic signed [31:0] a_imag;
      logic signed [31:0] b_real;
      logic signed [31:0] b_imag;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] res_real;
      logic signed [31:0] res_imag;
      logic               overflow;
      logic               div_by_zero;
   } rsp_word_type;

   // products stage
   typedef struct packed {
      op_type             op;
      rsp_word_type       addsub;
      logic signed [63:0] p_rr;
      logic signed [63:0] p_ii;
      logic signed [63:0] p_ri;
      logic signed [63:0] p_ir;
      logic signed [63:0] sq_r;
      logic signed [63:0] sq_i;
   } mult_word_type;

   // sums stage
   typedef struct packed {
      op_type             op;
      rsp_word_type       addsub;
      logic signed [64:0] m_re;
      logic signed [64:0] m_im;
      logic signed [64:0] n_re;
      logic signed [64:0] n_im;
      logic [63:0]        d;
   } comb_word_type;

   // one quotient lane of the divider
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] num_lo;
      logic [31:0] quo;
      logic        neg;
      logic        big;
   } lane_type;

   typedef struct packed {
      op_type       op;
      rsp_word_type fixed;
      logic         dz;
      logic [63:0]  d;
      lane_type     re;
      lane_type     im;
   } div_word_type;

   // 33-bit signed sum to 32 bits, saturating; bit 32 of the result is overflow
   function automatic logic [32:0] sat33(input logic signed [32:0] s);
      logic [32:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
      end else begin
         r = {1'b0, s[31:0]};
      end
      return r;
   endfunction

   // 65-bit signed value to 32 bits, saturating; bit 32 is overflow
   function automatic logic [32:0] sat65(input logic signed [64:0] s);
      logic [32:0] r;
      if (s[64:31] != {34{s[64]}}) begin
         r = s[64] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
      end else begin
         r = {1'b0, s[31:0]};
      end
      return r;
   endfunction

   // sign and quotient magnitude to 32 bits, saturating; bit 32 is overflow
   function automatic logic [32:0] from_mag(input lane_type l);
      logic [32:0] r;
      if (!l.neg) begin
         if (l.big || l.quo[31]) r = {1'b1, 32'h7FFF_FFFF};
         else                    r = {1'b0, l.quo};
      end else begin
         if (l.big || (l.quo > 32'h8000_0000)) r = {1'b1, 32'h8000_0000};
         else                                  r = {1'b0, 32'(32'd0 - l.quo)};
      end
      return r;
   endfunction

endpackage

[design/cau_mult.sv]
// First stage: the six operand products plus add and subtract.
module cau_mult (
   input  logic                   clock,
   input  logic                   en,
   input  cau_pkg::req_word_type  data_in,
   output cau_pkg::mult_word_type data_ff
);

   cau_pkg::mult_word_type nxt;
   logic signed [32:0] s_re;
   logic signed [32:0] s_im;
   logic [32:0] sat_re;
   logic [32:0] sat_im;

   always_comb begin
      nxt.op = cau_pkg::op_type'(data_in.req_type);
      if (nxt.op == cau_pkg::OP_SUB) begin
         s_re = 33'(data_in.a_real) - 33'(data_in.b_real);
         s_im = 33'(data_in.a_imag) - 33'(data_in.b_imag);
      end else begin
         s_re = 33'(data_in.a_real) + 33'(data_in.b_real);
         s_im = 33'(data_in.a_imag) + 33'(data_in.b_imag);
      end
      sat_re = cau_pkg::sat33(s_re);
      sat_im = cau_pkg::sat33(s_im);
      nxt.addsub.res_real    = sat_re[31:0];
      nxt.addsub.res_imag    = sat_im[31:0];
      nxt.addsub.overflow    = sat_re[32] | sat_im[32];
      nxt.addsub.div_by_zero = 1'b0;
      nxt.p_rr = 64'(data_in.a_real) * 64'(data_in.b_real);
      nxt.p_ii = 64'(data_in.a_imag) * 64'(data_in.b_imag);
      nxt.p_ri = 64'(data_in.a_real) * 64'(data_in.b_imag);
      nxt.p_ir = 64'(data_in.a_imag) * 64'(data_in.b_real);
      nxt.sq_r = 64'(data_in.b_real) * 64'(data_in.b_real);
      nxt.sq_i = 64'(data_in.b_imag) * 64'(data_in.b_imag);
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= nxt;
   end

endmodule

[design/cau_combine.sv]
// Second stage: product sums for multiply and divide, and the divisor.
module cau_combine (
   input  logic                   clock,
   input  logic                   en,
   input  cau_pkg::mult_word_type data_in,
   output cau_pkg::comb_word_type data_ff
);

   cau_pkg::comb_word_type nxt;

   always_comb begin
      nxt.op     = data_in.op;
      nxt.addsub = data_in.addsub;
      nxt.m_re   = 65'(data_in.p_rr) - 65'(data_in.p_ii);
      nxt.m_im   = 65'(data_in.p_ri) + 65'(data_in.p_ir);
      nxt.n_re   = 65'(data_in.p_rr) + 65'(data_in.p_ii);
      nxt.n_im   = 65'(data_in.p_ir) - 65'(data_in.p_ri);
      nxt.d      = 64'(data_in.sq_r) + 64'(data_in.sq_i);
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= nxt;
   end

endmodule

[design/cau_prep.sv]
// Third stage: multiply scaling and saturation, divider lane setup.
module cau_prep #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   en,
   input  cau_pkg::comb_word_type data_in,
   output cau_pkg::div_word_type  data_ff
);

   localparam int HI_SHIFT = cau_pkg::WORD_BITS - FRAC_BITS;

   cau_pkg::div_word_type nxt;
   logic signed [64:0] sh_re;
   logic signed [64:0] sh_im;
   logic signed [64:0] nr;
   logic signed [64:0] ni;
   logic [32:0] sat_re;
   logic [32:0] sat_im;
   logic [63:0] mag_re;
   logic [63:0] mag_im;

   always_comb begin
      sh_re  = data_in.m_re >>> FRAC_BITS;   // floor scaling
      sh_im  = data_in.m_im >>> FRAC_BITS;
      sat_re = cau_pkg::sat65(sh_re);
      sat_im = cau_pkg::sat65(sh_im);
      nr     = data_in.n_re;
      ni     = data_in.n_im;
      mag_re = nr[64] ? 64'(-nr) : nr[63:0];
      mag_im = ni[64] ? 64'(-ni) : ni[63:0];

      nxt.op = data_in.op;
      nxt.d  = data_in.d;
      nxt.dz = (data_in.d == 64'd0);
      unique case (data_in.op)
         cau_pkg::OP_ADD, cau_pkg::OP_SUB: nxt.fixed = data_in.addsub;
         cau_pkg::OP_MUL: begin
            nxt.fixed.res_real    = sat_re[31:0];
            nxt.fixed.res_imag    = sat_im[31:0];
            nxt.fixed.overflow    = sat_re[32] | sat_im[32];
            nxt.fixed.div_by_zero = 1'b0;
         end
         cau_pkg::OP_DIV: begin
            nxt.fixed.res_real    = '0;
            nxt.fixed.res_imag    = '0;
            nxt.fixed.overflow    = 1'b0;
            nxt.fixed.div_by_zero = nxt.dz;
         end
         default: nxt.fixed = data_in.addsub;
      endcase

      // top of the scaled dividend; quotient overflows 32 bits when it reaches d
      nxt.re.rem    = mag_re >> HI_SHIFT;
      nxt.re.num_lo = 32'(mag_re << FRAC_BITS);
      nxt.re.quo    = '0;
      nxt.re.neg    = nr[64];
      nxt.re.big    = (nxt.re.rem >= data_in.d);
      nxt.im.rem    = mag_im >> HI_SHIFT;
      nxt.im.num_lo = 32'(mag_im << FRAC_BITS);
      nxt.im.quo    = '0;
      nxt.im.neg    = ni[64];
      nxt.im.big    = (nxt.im.rem >= data_in.d);
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= nxt;
   end

endmodule

[design/cau_div_step.sv]
// One restoring division step for both quotient lanes.
module cau_div_step (
   input  logic                  clock,
   input  logic                  en,
   input  cau_pkg::div_word_type data_in,
   output cau_pkg::div_word_type data_ff
);

   function automatic cau_pkg::lane_type step(input cau_pkg::lane_type l,
                                              input logic [63:0] d);
      cau_pkg::lane_type r;
      logic [64:0] rem2;
      logic        qb;
      rem2 = {l.rem, l.num_lo[31]};
      qb   = (rem2 >= {1'b0, d});
      r        = l;
      r.rem    = qb ? 64'(rem2 - {1'b0, d}) : rem2[63:0];
      r.num_lo = {l.num_lo[30:0], 1'b0};
      r.quo    = {l.quo[30:0], qb};
      return r;
   endfunction

   cau_pkg::div_word_type nxt;

   always_comb begin
      nxt    = data_in;
      nxt.re = step(data_in.re, data_in.d);
      nxt.im = step(data_in.im, data_in.d);
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= nxt;
   end

endmodule

[design/complex_arith_unit.sv]
// Top level of the pipelined complex add / subtract / multiply / divide unit.
//
//   channel   dir   handshake              word
//   req       in    req_valid, req_ready   req_word  (op, a, b in signed Q16.16)
//   rsp       out   rsp_valid, rsp_ready   rsp_word  (result, overflow, div_by_zero)
//
// One word per cycle sustained while rsp_ready stays high; 36 register stages: products, sums,
//   scaling and divider setup, 32 restoring divider steps (one quotient bit each),
//   output register.
// Every operation runs the full pipe so results leave in order.
// Each stage holds its own valid bit and loads when it is empty or its successor
//   moves, so bubbles close up and a stalled rsp fills the pipe before req_ready drops.
// Synchronous active-high reset clears the valid bits only.
module complex_arith_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cau_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cau_pkg::rsp_word_type rsp_word
);

   localparam int DIV_STEPS  = cau_pkg::QUO_BITS;
   localparam int NUM_STAGES = 3 + DIV_STEPS + 1;
   localparam int OUT_STG    = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   rdy;          // rdy[k]: stage k may load this cycle

   cau_pkg::mult_word_type mult_ff;
   cau_pkg::comb_word_type comb_ff;
   cau_pkg::div_word_type  div_bus [DIV_STEPS+1];
   cau_pkg::rsp_word_type  rsp_word_ff;
   cau_pkg::rsp_word_type  rsp_word_in;
   logic [32:0]            fin_re;
   logic [32:0]            fin_im;

   // ready ripples back from the output; empty stages always take a word
   assign rdy[NUM_STAGES] = rsp_ready;
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
      assign rdy[k] = !valid_ff[k] || rdy[k+1];
   end

   always_comb begin
      valid_in[0] = rdy[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   cau_mult u_mult (
      .clock   (clock),
      .en      (rdy[0]),
      .data_in (req_word),
      .data_ff (mult_ff)
   );

   cau_combine u_combine (
      .clock   (clock),
      .en      (rdy[1]),
      .data_in (mult_ff),
      .data_ff (comb_ff)
   );

   cau_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock   (clock),
      .en      (rdy[2]),
      .data_in (comb_ff),
      .data_ff (div_bus[0])
   );

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      cau_div_step u_step (
         .clock   (clock),
         .en      (rdy[3+j]),
         .data_in (div_bus[j]),
         .data_ff (div_bus[j+1])
      );
   end

   // a real divide takes the quotient lanes, everything else its early result
   always_comb begin
      fin_re = cau_pkg::from_mag(div_bus[DIV_STEPS].re);
      fin_im = cau_pkg::from_mag(div_bus[DIV_STEPS].im);
      if (div_bus[DIV_STEPS].op == cau_pkg::OP_DIV && !div_bus[DIV_STEPS].dz) begin
         rsp_word_in.res_real    = fin_re[31:0];
         rsp_word_in.res_imag    = fin_im[31:0];
         rsp_word_in.overflow    = fin_re[32] | fin_im[32];
         rsp_word_in.div_by_zero = 1'b0;
      end else begin
         rsp_word_in = div_bus[DIV_STEPS].fixed;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[OUT_STG]) rsp_word_ff <= rsp_word_in;
   end

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[OUT_STG];
   assign rsp_word  = rsp_word_ff;

endmodule
